// ----- rtl/uvf_pkg.sv -----
// Package for the unique value FIFO: depth, status codes, transaction types
// and the control bundle broadcast from the top level to the cell row.
// No dependencies.
package uvf_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned VALUE_W = 32;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic                      mode;
    logic signed [VALUE_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] value_out;
  } out_t;

  typedef struct packed {
    logic                      cmp_en;
    logic                      shift;
    logic                      enq;
    logic signed [VALUE_W-1:0] cmp_value;
    logic signed [VALUE_W-1:0] enq_value;
  } cell_ctrl_t;

endpackage

// ----- rtl/uvf_cell.sv -----
// One storage cell of the unique value FIFO: a value, its valid bit and a
// registered match flag. Takes its neighbor's value on a dequeue shift.
// Depends on uvf_pkg.
module uvf_cell import uvf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cell_ctrl_t                ctrl_i,
  input  logic                      prev_valid_i,
  input  logic                      next_valid_i,
  input  logic signed [VALUE_W-1:0] next_value_i,
  output logic                      valid_o,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      match_o
);

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      match_q, match_d;
  logic                      load;

  assign load = ctrl_i.enq && !valid_q && prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
    end else if (load) begin
      valid_d = 1'b1;
      value_d = ctrl_i.enq_value;
    end
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_q && (value_q == ctrl_i.cmp_value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ----- rtl/unique_value_fifo_unit.sv -----
// Top level of the unique value FIFO: handshake, command register, result
// register and the row of uvf_cell storage cells.
// Depends on uvf_pkg and uvf_cell.
//
// A FIFO of up to DEPTH signed 32-bit values that holds each value at most
// once. Every input transaction (enqueue or dequeue) returns exactly one
// result transaction with a status and, for a dequeue, the oldest value.
// A full queue wins over a duplicate. Each transaction has two steps:
// in the first, every cell compares its value with the incoming one in
// parallel and registers a match flag; in the second, which waits while
// an earlier result is held unaccepted in the output register, the flags
// are combined, the cell row is updated (shifted toward the oldest cell
// on a dequeue, filled at the first free cell on an enqueue) and the
// result is written to the output register. A new transaction is accepted
// while a result waits in that register, but not before the last commits.
module unique_value_fifo_unit import uvf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic                      busy_q, busy_d;
  in_t                       cmd_q;
  logic                      out_valid_q, out_valid_d;
  out_t                      out_q, out_d;
  logic                      accept, commit;
  logic                      full, empty, dup;
  cell_ctrl_t                ctrl;
  logic [DEPTH-1:0]          vld;
  logic [DEPTH-1:0]          match;
  logic signed [VALUE_W-1:0] val [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                      prev_valid;
      logic                      next_valid;
      logic signed [VALUE_W-1:0] next_value;
      if (gi == 0) begin : g_first
        assign prev_valid = 1'b1;
      end else begin : g_prev
        assign prev_valid = vld[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_valid = 1'b0;
        assign next_value = '0;
      end else begin : g_next
        assign next_valid = vld[gi+1];
        assign next_value = val[gi+1];
      end
      uvf_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .prev_valid_i (prev_valid),
        .next_valid_i (next_valid),
        .next_value_i (next_value),
        .valid_o      (vld[gi]),
        .value_o      (val[gi]),
        .match_o      (match[gi])
      );
    end
  endgenerate

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = busy_q && (!out_valid_q || out_ready_i);

  assign full  = vld[DEPTH-1];
  assign empty = !vld[0];
  assign dup   = |match;

  always_comb begin
    ctrl.cmp_en    = accept;
    ctrl.cmp_value = in_data_i.value_in;
    ctrl.enq_value = cmd_q.value_in;
    ctrl.shift     = commit && (cmd_q.mode == MODE_DEQUEUE) && !empty;
    ctrl.enq       = commit && (cmd_q.mode == MODE_ENQUEUE) && !full && !dup;
  end

  always_comb begin
    out_d.value_out = '0;
    if (cmd_q.mode == MODE_ENQUEUE) begin
      if (full) begin
        out_d.status = ST_FULL;
      end else if (dup) begin
        out_d.status = ST_DUPLICATE;
      end else begin
        out_d.status = ST_ENQUEUED;
      end
    end else begin
      if (empty) begin
        out_d.status = ST_EMPTY;
      end else begin
        out_d.status    = ST_DEQUEUED;
        out_d.value_out = val[0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (commit) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, vld} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("cell valid bits not contiguous from the oldest cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.shift |=> $countones(vld) == $past($countones(vld)) - 1)
    else $error("dequeue did not drop exactly one entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> $countones(vld) == $past($countones(vld)) + 1)
    else $error("enqueue did not add exactly one entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_DEQUEUED) |-> out_data_o.value_out == '0)
    else $error("nonzero value on a result that is not a dequeue");

endmodule
